### hdl/kpi_pkg.sv
// ----------------------------------------------------------------------------
// kpi_pkg
// Shared types for the keyframe position interpolator: channel beats,
// datapath operations, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package kpi_pkg;

  // Input beat: one keyframe append or one time advance.
  typedef struct packed {
    logic               mode;
    logic        [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic        [31:0] delta_time;
  } in_item_t;

  // Output beat: one interpolated position.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [5:0]  segment_index;
    logic        [16:0] blend;
    logic               finished;
    logic               too_few_keys;
  } out_item_t;

  localparam logic MODE_APPEND = 1'b0;

  localparam logic [16:0] BLEND_ONE = 17'h10000;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_ADVANCE,
    OP_SRCH,
    OP_PASS,
    OP_ENDPAIR,
    OP_MOD_INIT,
    OP_MOD_STEP,
    OP_MOD_DONE,
    OP_CLAMP,
    OP_CAP0,
    OP_CAP1,
    OP_DIV_STEP,
    OP_MUL,
    OP_ADD,
    OP_EMIT
  } op_t;

  // Key memory read address source.
  typedef enum logic [1:0] {
    RSEL_IDX,
    RSEL_SEG,
    RSEL_SEG1
  } rsel_t;

  typedef struct packed {
    op_t   op;
    rsel_t rsel;
    logic  held;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic ended;
    logic hit;
    logic at_last;
    logic last_step;
    logic need_div;
    logic lane_last;
    logic out_free;
  } sts_t;

endpackage

### hdl/kpi_ram.sv
// ----------------------------------------------------------------------------
// kpi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kpi_ram #(
  parameter int W = 128,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/kpi_ctrl.sv
// ----------------------------------------------------------------------------
// kpi_ctrl
// Controller: sequences search, wrap, divide and lerp for one time advance,
// and takes keyframe appends without leaving the idle state.
// ----------------------------------------------------------------------------
module kpi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_stall,
  output kpi_pkg::cmd_t cmd,
  input  kpi_pkg::sts_t sts
);
  import kpi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HELD, S_RD, S_CMP, S_PASS, S_CHK, S_MOD, S_MODEND,
    S_CLAMP, S_A, S_B, S_C, S_DIV, S_MUL, S_ADD, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd.op     = OP_NONE;
    cmd.rsel   = RSEL_IDX;
    cmd.held   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_APPEND) begin
            cmd.op = OP_WRITE;
          end else if (sts.few || sts.ended) begin
            state_nxt = S_HELD;
          end else begin
            cmd.op     = OP_ADVANCE;
            second_nxt = 1'b0;
            state_nxt  = S_RD;
          end
        end
      end
      S_HELD: begin
        cmd.held = 1'b1;
        if (sts.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.op = OP_SRCH;
        if (sts.hit) begin
          state_nxt = S_A;
        end else if (sts.at_last) begin
          state_nxt = second_r ? S_CLAMP : S_PASS;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_PASS: begin
        cmd.op    = OP_PASS;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.ended) begin
          cmd.op    = OP_ENDPAIR;
          state_nxt = S_A;
        end else begin
          cmd.op    = OP_MOD_INIT;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.op = OP_MOD_STEP;
        if (sts.last_step) begin
          state_nxt = S_MODEND;
        end
      end
      S_MODEND: begin
        cmd.op     = OP_MOD_DONE;
        second_nxt = 1'b1;
        state_nxt  = S_RD;
      end
      S_CLAMP: begin
        cmd.op    = OP_CLAMP;
        state_nxt = S_A;
      end
      S_A: begin
        cmd.rsel  = RSEL_SEG;
        state_nxt = S_B;
      end
      S_B: begin
        cmd.rsel  = RSEL_SEG1;
        cmd.op    = OP_CAP0;
        state_nxt = S_C;
      end
      S_C: begin
        cmd.op    = OP_CAP1;
        state_nxt = sts.need_div ? S_DIV : S_MUL;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.last_step) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.op    = OP_ADD;
        state_nxt = sts.lane_last ? S_EMIT : S_MUL;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

### hdl/kpi_dp.sv
// ----------------------------------------------------------------------------
// kpi_dp
// Datapath: key memory, running clock, pass counter, shared shift-subtract
// unit for the wrap modulo and the blend divide, one multiplier for the lerp,
// and the output register.
// ----------------------------------------------------------------------------
module kpi_dp #(
  parameter int MAX_KEYS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kpi_pkg::in_item_t    in_item,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  kpi_pkg::cmd_t        cmd,
  output kpi_pkg::sts_t        sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kpi_pkg::out_item_t   out_item
);
  import kpi_pkg::*;

  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  // Control state.
  logic [15:0]        limit_r;
  logic [CW-1:0]      kc_r;
  logic [31:0]        clock_r;
  logic [IW-1:0]      frame_r;
  logic [15:0]        passes_r;
  logic               out_valid_r;
  logic [5:0]         cnt_r;
  logic [1:0]         lane_r;
  logic               fix_r;
  // Payload.
  logic [CW-1:0]      idx_r;
  logic [IW-1:0]      seg_r;
  logic [16:0]        blend_r;
  logic [31:0]        last_t_r;
  logic [31:0]        t0_r;
  logic [32:0]        rem_r;
  logic [31:0]        dvs_r;
  logic signed [31:0] a_r [3];
  logic signed [31:0] b_r [3];
  logic signed [31:0] held_r [3];
  logic signed [50:0] prod_r;
  out_item_t          out_r;

  // Key memory: time, x, y, z in one word.
  logic           ram_we;
  logic [IW-1:0]  ram_raddr;
  logic [127:0]   ram_rdata;
  logic [31:0]    rd_t;

  assign ram_we = (cmd.op == OP_WRITE) && (kc_r < CW'(MAX_KEYS));
  assign rd_t   = ram_rdata[127:96];

  always_comb begin
    unique case (cmd.rsel)
      RSEL_SEG:  ram_raddr = seg_r;
      RSEL_SEG1: ram_raddr = seg_r + IW'(1);
      default:   ram_raddr = idx_r[IW-1:0];
    endcase
  end

  kpi_ram #(.W(128), .D(MAX_KEYS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (kc_r[IW-1:0]),
    .wdata ({in_item.key_time, in_item.key_x, in_item.key_y, in_item.key_z}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status toward the controller.
  logic        ended;
  logic [32:0] clk_sum;
  logic [31:0] dc, dt;
  logic [32:0] r2;
  logic        ge;

  assign ended   = (limit_r != 16'd0) && (passes_r >= limit_r);
  assign clk_sum = {1'b0, clock_r} + {1'b0, in_item.delta_time};
  assign dc      = clock_r - t0_r;
  assign dt      = rd_t - t0_r;

  // One shift-subtract step; the modulo shifts in clock bits, the divide zeros.
  assign r2 = {rem_r[31:0], (cmd.op == OP_MOD_STEP) ? clock_r[31] : 1'b0};
  assign ge = (r2 >= {1'b0, dvs_r});

  always_comb begin
    sts.few       = (kc_r < CW'(2));
    sts.ended     = ended;
    sts.hit       = (clock_r <= rd_t);
    sts.at_last   = (idx_r == kc_r - CW'(1));
    sts.last_step = (cnt_r == 6'd1);
    sts.need_div  = !fix_r && (rd_t > t0_r) && (clock_r > t0_r) && (dc < dt);
    sts.lane_last = (lane_r == 2'd2);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '0;
      kc_r        <= '0;
      clock_r     <= '0;
      frame_r     <= '0;
      passes_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      lane_r      <= '0;
      fix_r       <= 1'b0;
      held_r[0]   <= '0;
      held_r[1]   <= '0;
      held_r[2]   <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      // The output register fills on an emit and empties when its beat is taken.
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_WRITE: begin
          if (ram_we) begin
            kc_r <= kc_r + CW'(1);
          end
        end
        OP_ADVANCE: begin
          clock_r <= clk_sum[32] ? 32'hFFFF_FFFF : clk_sum[31:0];
          fix_r   <= 1'b0;
        end
        OP_PASS: begin
          if (passes_r != 16'hFFFF) begin
            passes_r <= passes_r + 16'd1;
          end
        end
        OP_ENDPAIR:  fix_r <= 1'b1;
        OP_MOD_INIT: cnt_r <= 6'd32;
        OP_MOD_STEP: begin
          cnt_r   <= cnt_r - 6'd1;
          clock_r <= {clock_r[30:0], 1'b0};
        end
        OP_MOD_DONE: clock_r <= (last_t_r == 32'd0) ? 32'd0 : rem_r[31:0];
        OP_CAP1: begin
          cnt_r  <= 6'd16;
          lane_r <= '0;
        end
        OP_DIV_STEP: cnt_r <= cnt_r - 6'd1;
        OP_ADD: begin
          held_r[lane_r] <= a_r[lane_r] + prod_r[47:16];
          lane_r         <= lane_r + 2'd1;
        end
        OP_EMIT: begin
          if (!cmd.held) begin
            frame_r <= seg_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ADVANCE: idx_r <= CW'(frame_r) + CW'(1);
      OP_SRCH: begin
        if (clock_r <= rd_t) begin
          seg_r <= IW'(idx_r - CW'(1));
        end else if (idx_r == kc_r - CW'(1)) begin
          last_t_r <= rd_t;
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
      OP_ENDPAIR: begin
        seg_r   <= IW'(kc_r - CW'(2));
        blend_r <= BLEND_ONE;
      end
      OP_MOD_INIT: begin
        rem_r <= '0;
        dvs_r <= last_t_r;
      end
      OP_MOD_STEP, OP_DIV_STEP: begin
        rem_r <= ge ? (r2 - {1'b0, dvs_r}) : r2;
        if (cmd.op == OP_DIV_STEP) begin
          blend_r <= {blend_r[15:0], ge};
        end
      end
      OP_MOD_DONE: idx_r <= CW'(1);
      OP_CLAMP:    seg_r <= IW'(kc_r - CW'(2));
      OP_CAP0: begin
        t0_r   <= rd_t;
        a_r[0] <= ram_rdata[95:64];
        a_r[1] <= ram_rdata[63:32];
        a_r[2] <= ram_rdata[31:0];
      end
      OP_CAP1: begin
        b_r[0] <= ram_rdata[95:64];
        b_r[1] <= ram_rdata[63:32];
        b_r[2] <= ram_rdata[31:0];
        if (!fix_r) begin
          if (rd_t <= t0_r) begin
            blend_r <= BLEND_ONE;
          end else if (clock_r <= t0_r) begin
            blend_r <= '0;
          end else if (dc >= dt) begin
            blend_r <= BLEND_ONE;
          end else begin
            blend_r <= '0;
            rem_r   <= {1'b0, dc};
            dvs_r   <= dt;
          end
        end
      end
      OP_MUL: begin
        prod_r <= 51'((34'(b_r[lane_r]) - 34'(a_r[lane_r])) * $signed({1'b0, blend_r}));
      end
      OP_EMIT: begin
        out_r.pos_x        <= held_r[0];
        out_r.pos_y        <= held_r[1];
        out_r.pos_z        <= held_r[2];
        out_r.too_few_keys <= cmd.held && (kc_r < CW'(2));
        out_r.finished     <= ended;
        if (cmd.held) begin
          out_r.segment_index <= 6'(frame_r);
          out_r.blend         <= ended ? BLEND_ONE : 17'd0;
        end else begin
          out_r.segment_index <= 6'(seg_r);
          out_r.blend         <= blend_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### hdl/keyframe_position_interpolator_unit.sv
// ----------------------------------------------------------------------------
// keyframe_position_interpolator_unit
// Linear keyframe interpolation in Q16.16: appends keyframes, advances a
// saturating clock, finds the bracketing pair, divides for the blend and
// lerps x, y and z.
//
//   channel | ports                          | beat
//   input   | in_valid, in_stall, in_item    | append key or advance time
//   output  | out_valid, out_stall, out_item | interpolated position
//   config  | cfg_we, cfg_wdata              | repeat limit
//
// An append is written straight from idle. An advance takes the beat, then
// searches key by key, reads the pair, runs the shift-subtract blend divide
// when needed, does the three lerps on one shared multiplier and loads the
// output register; a wrap adds the pass count, the check, the modulo steps
// and the final update, then a second search from the first segment, and an
// ending pass goes straight to the last pair. Held results go straight to
// the output register. The search and the shift-subtract unit take most time.
// Reset is synchronous on rst_n; the key memory needs no clearing pass.
// A stalled output beat waits in the output register while the next input
// beat is taken; a new result waits until that register is free.
// ----------------------------------------------------------------------------
module keyframe_position_interpolator_unit #(
  parameter int MAX_KEYS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kpi_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output kpi_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import kpi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_item.mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  kpi_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
